// File: sv/status_histogram_masked_sum_unit_macros.svh
// ----------------------------------------------------------------------------
// status_histogram_masked_sum_unit_macros
// Assertion macros for the status histogram masked-sum unit.
// ----------------------------------------------------------------------------
`ifndef STATUS_HISTOGRAM_MASKED_SUM_UNIT_MACROS_SVH
`define STATUS_HISTOGRAM_MASKED_SUM_UNIT_MACROS_SVH

// same-cycle implication
`define SHMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/shms_pkg.sv
// ----------------------------------------------------------------------------
// shms_pkg
// Shared types and constants of the status histogram masked-sum unit.
// ----------------------------------------------------------------------------
package shms_pkg;

    localparam int unsigned FLAG_PORT_W = 9;
    localparam int unsigned SUM_PORT_W  = 32;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic clearing;
        logic counting;
        logic scanning;
        logic result;
    } t_seq_status;

endpackage

// File: sv/shms_ram.sv
// ----------------------------------------------------------------------------
// shms_ram
// Single-port bin memory with registered read data.
// ----------------------------------------------------------------------------
module shms_ram #(
    parameter int unsigned ADDR_BITS  = 9,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_BITS-1:0]  i_addr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/shms_ctrl.sv
// ----------------------------------------------------------------------------
// shms_ctrl
// Sequencer with one shared adder: clear sweep, bin increment, masked scan.
// ----------------------------------------------------------------------------
module shms_ctrl
    import shms_pkg::*;
#(
    parameter int unsigned FLAG_BITS   = 9,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic [FLAG_PORT_W-1:0] i_status_word,
    input  logic [FLAG_PORT_W-1:0] i_must_mask,
    input  logic [FLAG_PORT_W-1:0] i_must_not_mask,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SUM_PORT_W-1:0]  o_bin_sum,
    output logic                   o_ram_we,
    output logic [FLAG_BITS-1:0]   o_ram_addr,
    output logic [COUNT_WIDTH-1:0] o_ram_wdata,
    input  logic [COUNT_WIDTH-1:0] i_ram_rdata,
    output t_seq_status            o_status
);

    localparam int unsigned MW = (FLAG_BITS > FLAG_PORT_W) ? FLAG_BITS : FLAG_PORT_W;
    localparam int unsigned SW = (COUNT_WIDTH > SUM_PORT_W) ? COUNT_WIDTH : SUM_PORT_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CNT_RD = 3'd2;
    localparam logic [2:0] ST_CNT_WR = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [FLAG_BITS:0]     r_cnt, n_cnt;
    logic [FLAG_BITS-1:0]   r_bin, n_bin;
    logic [MW-1:0]          r_must, n_must;
    logic [MW-1:0]          r_must_not, n_must_not;
    logic [COUNT_WIDTH-1:0] r_acc, n_acc;
    logic                   r_pend, n_pend;
    logic                   r_pend_match, n_pend_match;
    logic                   r_out_valid, n_out_valid;
    logic [SUM_PORT_W-1:0]  r_out_sum, n_out_sum;

    logic                   accept;
    logic                   issue;
    logic                   idx_match;
    logic [MW-1:0]          idx_w;
    logic [COUNT_WIDTH-1:0] add_a;
    logic [COUNT_WIDTH-1:0] add_b;
    logic [COUNT_WIDTH-1:0] add_sum;
    logic [SW-1:0]          acc_w;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign issue  = !r_cnt[FLAG_BITS];

    assign idx_w     = MW'(r_cnt[FLAG_BITS-1:0]);
    assign idx_match = ((idx_w & r_must) == r_must) && ((idx_w & r_must_not) == '0);

    // shared adder
    assign add_a   = ((r_state == ST_CNT_WR) || r_pend_match) ? i_ram_rdata : '0;
    assign add_b   = (r_state == ST_CNT_WR) ? COUNT_WIDTH'(1) : r_acc;
    assign add_sum = add_a + add_b;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_bin        = r_bin;
        n_must       = r_must;
        n_must_not   = r_must_not;
        n_acc        = r_acc;
        n_pend       = 1'b0;
        n_pend_match = 1'b0;
        n_out_valid  = r_out_valid && i_stall;
        n_out_sum    = r_out_sum;
        o_ram_we     = 1'b0;
        o_ram_addr   = r_cnt[FLAG_BITS-1:0];
        o_ram_wdata  = '0;
        case (r_state)
            ST_CLEAR: begin
                if (issue) begin
                    o_ram_we = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_bin      = FLAG_BITS'(i_status_word);
                    n_must     = MW'(i_must_mask);
                    n_must_not = MW'(i_must_not_mask);
                    n_cnt      = '0;
                    n_acc      = '0;
                    if (i_action == ACT_QUERY) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_CNT_RD;
                    end
                end
            end
            ST_CNT_RD: begin
                o_ram_addr = r_bin;
                n_state    = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                o_ram_addr  = r_bin;
                o_ram_we    = 1'b1;
                o_ram_wdata = add_sum;
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_pend) begin
                    n_acc = add_sum;
                end
                if (issue) begin
                    n_cnt        = r_cnt + 1'b1;
                    n_pend       = 1'b1;
                    n_pend_match = idx_match;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = acc_w[SUM_PORT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_bin        <= n_bin;
        r_must       <= n_must;
        r_must_not   <= n_must_not;
        r_acc        <= n_acc;
        r_pend_match <= n_pend_match;
        r_out_sum    <= n_out_sum;
    end

    assign acc_w     = SW'(r_acc);
    assign o_bin_sum = r_out_sum;
    assign o_valid   = r_out_valid;
    assign o_stall   = (r_state != ST_IDLE);

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.counting = (r_state == ST_CNT_RD) || (r_state == ST_CNT_WR);
    assign o_status.scanning = (r_state == ST_SCAN);
    assign o_status.result   = (r_state == ST_OUT);

endmodule

// File: sv/status_histogram_masked_sum_unit.sv
// ----------------------------------------------------------------------------
// status_histogram_masked_sum_unit
// Histogram of status words with a masked bin-sum query.
// ----------------------------------------------------------------------------
// One item at a time. A count beat reads the bin, adds one and writes it
// back through the single memory port. A query beat walks all 2^FLAG_BITS
// bins through one adder, one bin per cycle, then moves the sum into the
// output register: the result beat shows in the same cycle that the input
// is free again. A result waiting on the output only holds up a later
// query, which keeps its sum until the output register is free; counts go
// on. After reset a clearing pass zeroes the bin memory, with the input
// stalled. Sums wrap modulo 2^COUNT_WIDTH and are cut or zero extended to
// 32 bits.
// ----------------------------------------------------------------------------
`include "status_histogram_masked_sum_unit_macros.svh"

module status_histogram_masked_sum_unit
    import shms_pkg::*;
#(
    parameter int unsigned FLAG_BITS   = 9,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic [FLAG_PORT_W-1:0] i_status_word,
    input  logic [FLAG_PORT_W-1:0] i_must_mask,
    input  logic [FLAG_PORT_W-1:0] i_must_not_mask,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SUM_PORT_W-1:0]  o_bin_sum
);

    logic                   ram_we;
    logic [FLAG_BITS-1:0]   ram_addr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    t_seq_status            seq_status;

    shms_ctrl #(
        .FLAG_BITS   (FLAG_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_status_word   (i_status_word),
        .i_must_mask     (i_must_mask),
        .i_must_not_mask (i_must_not_mask),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_bin_sum       (o_bin_sum),
        .o_ram_we        (ram_we),
        .o_ram_addr      (ram_addr),
        .o_ram_wdata     (ram_wdata),
        .i_ram_rdata     (ram_rdata),
        .o_status        (seq_status)
    );

    shms_ram #(
        .ADDR_BITS  (FLAG_BITS),
        .DATA_WIDTH (COUNT_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    `SHMS_ASSERT_IMP(a_clear_stalls, i_clk, i_rst_n, seq_status.clearing, o_stall && !o_valid, "input taken during clear")
    `SHMS_ASSERT_IMP(a_result_stalls, i_clk, i_rst_n, seq_status.result, o_stall, "input taken while result pending")
    `SHMS_ASSERT_NXT(a_count_no_result, i_clk, i_rst_n, i_valid && !o_stall && (i_action == ACT_COUNT), seq_status.counting && !seq_status.result, "count beat produced a result")
    `SHMS_ASSERT_IMP(a_result_after_scan, i_clk, i_rst_n, $rose(o_valid), $past(seq_status.result), "result without scan")

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the status histogram masked-sum unit. A short
// table of count and query beats, some with sums known after reset, is
// followed by random traffic. Untyped query sums are predicted from a
// local copy of the histogram, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import shms_pkg::*;

    localparam int NUM_BINS      = 1 << FLAG_PORT_W;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int DRAIN_CYCLES  = NUM_BINS + 16;
    localparam int DIRECTED_ROWS = 16;

    typedef logic [FLAG_PORT_W-1:0] t_flag;
    typedef logic [SUM_PORT_W-1:0]  t_sum;

    typedef struct packed {
        logic  action;
        t_flag word;
        t_flag must;
        t_flag must_not;
        logic  typed;
        t_sum  sum;
    } t_stim_row;

    // typed sums hold only where the histogram is obvious from the rows above
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ACT_QUERY, 9'h000, 9'h000, 9'h000, 1'b1, 32'd0},
        '{ACT_QUERY, 9'h1FF, 9'h1FF, 9'h1FF, 1'b1, 32'd0},
        '{ACT_COUNT, 9'h000, 9'h1FF, 9'h1FF, 1'b0, 32'd0},
        '{ACT_COUNT, 9'h1FF, 9'h000, 9'h000, 1'b0, 32'd0},
        '{ACT_COUNT, 9'h155, 9'h0AA, 9'h155, 1'b0, 32'd0},
        '{ACT_COUNT, 9'h0AA, 9'h000, 9'h000, 1'b0, 32'd0},
        '{ACT_COUNT, 9'h1FF, 9'h155, 9'h0AA, 1'b0, 32'd0},
        '{ACT_QUERY, 9'h000, 9'h1FF, 9'h000, 1'b1, 32'd2},
        '{ACT_QUERY, 9'h000, 9'h000, 9'h1FF, 1'b1, 32'd1},
        '{ACT_QUERY, 9'h1FF, 9'h000, 9'h000, 1'b1, 32'd5},
        '{ACT_QUERY, 9'h000, 9'h001, 9'h001, 1'b1, 32'd0},
        '{ACT_QUERY, 9'h0AA, 9'h155, 9'h000, 1'b0, 32'd0},
        '{ACT_QUERY, 9'h000, 9'h0AA, 9'h155, 1'b0, 32'd0},
        '{ACT_QUERY, 9'h155, 9'h100, 9'h001, 1'b0, 32'd0},
        '{ACT_COUNT, 9'h100, 9'h000, 9'h000, 1'b0, 32'd0},
        '{ACT_QUERY, 9'h000, 9'h000, 9'h0AA, 1'b0, 32'd0}
    };

    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  i_valid         = 1'b0;
    logic  o_stall;
    logic  i_action        = ACT_COUNT;
    t_flag i_status_word   = '0;
    t_flag i_must_mask     = '0;
    t_flag i_must_not_mask = '0;
    logic  o_valid;
    logic  i_stall         = 1'b0;
    t_sum  o_bin_sum;

    t_sum  bin_tally [NUM_BINS] = '{default: '0};
    t_sum  pending_sums [$];
    t_sum  expected_sum;
    int    mismatch_count = 0;
    int    send_quiet     = 0;
    int    recv_quiet     = 0;
    int    recv_hold      = 0;

    status_histogram_masked_sum_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_status_word   (i_status_word),
        .i_must_mask     (i_must_mask),
        .i_must_not_mask (i_must_not_mask),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_bin_sum       (o_bin_sum)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sum masked_bin_total(input t_flag must, input t_flag must_not);
        t_sum  total;
        t_flag idx;
        total = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            idx = t_flag'(b);
            if ((idx & must) == must && (idx & must_not) == '0) begin
                total = total + bin_tally[b];
            end
        end
        return total;
    endfunction

    // random wait, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = int'($urandom_range(10, 40));
            return 0;
        end
        return int'($urandom_range(0, 8));
    endfunction

    task automatic offer_beat(input logic act, input t_flag word, input t_flag must,
                              input t_flag must_not, input logic typed, input t_sum sum);
        int   gap;
        t_sum want;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_status_word   <= word;
        i_must_mask     <= must;
        i_must_not_mask <= must_not;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (act == ACT_COUNT) begin
            bin_tally[word] = bin_tally[word] + 1'b1;
        end else begin
            want         = typed ? sum : masked_bin_total(must, must_not);
            pending_sums = {pending_sums, want};
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_sums.size() == 0) begin
                    $display("%0t: bin_sum beat with nothing expected, got %h",
                             $time, o_bin_sum);
                    mismatch_count++;
                end else begin
                    expected_sum = pending_sums.pop_front();
                    if (o_bin_sum !== expected_sum) begin
                        $display("%0t: bin_sum mismatch, expected %h got %h",
                                 $time, expected_sum, o_bin_sum);
                        mismatch_count++;
                    end
                end
                recv_hold = draw_wait(recv_quiet);
            end
            i_stall <= (recv_hold > 0);
            if (recv_hold > 0 && o_valid) begin
                recv_hold--;
            end
        end
    end

    initial begin
        t_flag hot_words [4];
        t_flag word;
        t_flag must;
        t_flag must_not;
        int    items;

        items = 0;
        foreach (hot_words[h]) hot_words[h] = t_flag'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_beat(directed_rows[r].action, directed_rows[r].word,
                       directed_rows[r].must, directed_rows[r].must_not,
                       directed_rows[r].typed, directed_rows[r].sum);
        end

        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        must     = '0;
                        must_not = '0;
                    end
                    1: begin
                        must     = t_flag'($urandom);
                        must_not = t_flag'($urandom);
                    end
                    2: begin
                        // a bit in both masks
                        must     = t_flag'($urandom & $urandom)
                                 | (t_flag'(1) << $urandom_range(0, FLAG_PORT_W - 1));
                        must_not = t_flag'($urandom & $urandom) | must;
                    end
                    default: begin
                        must     = t_flag'($urandom & $urandom & $urandom);
                        must_not = t_flag'($urandom & $urandom & $urandom);
                    end
                endcase
                offer_beat(ACT_QUERY, t_flag'($urandom), must, must_not, 1'b0, '0);
            end else begin
                case ($urandom_range(0, 2))
                    0:       word = t_flag'($urandom);
                    1:       word = hot_words[$urandom_range(0, 3)];
                    default: word = t_flag'($urandom & $urandom);
                endcase
                offer_beat(ACT_COUNT, word, t_flag'($urandom), t_flag'($urandom), 1'b0, '0);
            end
            items++;
        end

        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
